// ===== sv/tsha_pkg.sv =====
`timescale 1ns / 1ps

package tsha_pkg;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_FREE  = 2'd2;
   localparam logic [1:0] FUNC_CLEAR = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_BAD_READ = 2'd2;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd3;

   localparam logic [31:0] HANDLE_BASE_RESET = 32'd1000;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] value;
      logic [31:0]        handle;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [31:0]        handle_out;
      logic signed [31:0] value_out;
      logic [31:0]        alloc_total;
      logic [31:0]        free_total;
      logic [8:0]         live_slots;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic done;
   } dp_status_type;

endpackage

// ===== sv/tsha_ram.sv =====
`timescale 1ns / 1ps

module tsha_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tsha_dp.sv =====
`timescale 1ns / 1ps

module tsha_dp
   import tsha_pkg::*;
#(
   parameter int SLOTS = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [31:0]   csr_wr_data,
   input  req_type       req_data,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output rsp_type       rsp_data
);

   localparam int IW = $clog2(SLOTS);
   localparam int LW = $clog2(SLOTS + 1);

   logic [31:0]       base_ff, base_in;
   logic [31:0]       next_ff, next_in;
   logic [31:0]       alloc_ff, alloc_in;
   logic [31:0]       free_ff, free_in;
   logic [LW-1:0]     live_ff, live_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   req_type           req_ff, req_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic              issue_ff, issue_in;
   logic [IW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic              found_ff, found_in;
   logic [IW-1:0]     found_idx_ff, found_idx_in;
   logic signed [31:0] found_data_ff, found_data_in;
   rsp_type           rsp_ff, rsp_in;

   logic [63:0] rd_data;
   logic        ram_wr_en;
   logic        full;
   logic        is_lookup;
   logic        trivial;
   logic        alloc_hit;
   logic        tag_hit;
   logic        tag_miss;

   // tag in the upper word, data in the lower
   tsha_ram #(
      .WIDTH(64),
      .DEPTH(SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(found_idx_ff),
      .wr_data({next_ff, req_ff.value}),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   assign full      = (live_ff == LW'(SLOTS));
   assign is_lookup = (req_ff.func == FUNC_READ) || (req_ff.func == FUNC_FREE);
   assign trivial   = (req_ff.func == FUNC_CLEAR) || ((req_ff.func == FUNC_ALLOC) && full);
   assign alloc_hit = (req_ff.func == FUNC_ALLOC) && !full && issue_ff && !valid_ff[idx_ff];
   assign tag_hit   = is_lookup && cmp_vld_ff && valid_ff[cmp_idx_ff]
                      && (rd_data[63:32] == req_ff.handle);
   assign tag_miss  = is_lookup && cmp_vld_ff && (cmp_idx_ff == IW'(SLOTS - 1)) && !tag_hit;

   assign status.done = trivial || alloc_hit || tag_hit || tag_miss;
   assign ram_wr_en   = cmd.commit && (req_ff.func == FUNC_ALLOC) && found_ff;

   // scan sequencing
   always_comb begin
      req_in        = req_ff;
      idx_in        = idx_ff;
      issue_in      = issue_ff;
      cmp_idx_in    = idx_ff;
      cmp_vld_in    = issue_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_data_in = found_data_ff;
      if (issue_ff) begin
         if (idx_ff == IW'(SLOTS - 1)) begin
            issue_in = 1'b0;
         end else begin
            idx_in = idx_ff + IW'(1);
         end
      end
      if (cmd.scan && status.done) begin
         found_in = alloc_hit || tag_hit;
         if (alloc_hit) begin
            found_idx_in = idx_ff;
         end else begin
            found_idx_in = cmp_idx_ff;
         end
         found_data_in = $signed(rd_data[31:0]);
      end
      if (cmd.load) begin
         req_in     = req_data;
         idx_in     = '0;
         issue_in   = 1'b1;
         cmp_vld_in = 1'b0;
      end
   end

   // state update and result
   always_comb begin
      base_in  = csr_wr_en ? csr_wr_data : base_ff;
      next_in  = next_ff;
      alloc_in = alloc_ff;
      free_in  = free_ff;
      live_in  = live_ff;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (cmd.commit) begin
         rsp_in.status     = STATUS_OK;
         rsp_in.handle_out = '0;
         rsp_in.value_out  = '0;
         case (req_ff.func)
            FUNC_ALLOC: begin
               if (found_ff) begin
                  valid_in[found_idx_ff] = 1'b1;
                  rsp_in.handle_out      = next_ff;
                  next_in                = next_ff + 32'd1;
                  alloc_in               = alloc_ff + 32'd1;
                  live_in                = live_ff + LW'(1);
               end else begin
                  rsp_in.status = STATUS_FULL;
               end
            end
            FUNC_READ: begin
               if (found_ff) begin
                  rsp_in.value_out = found_data_ff;
               end else begin
                  rsp_in.status = STATUS_BAD_READ;
               end
            end
            FUNC_FREE: begin
               if (found_ff) begin
                  valid_in[found_idx_ff] = 1'b0;
                  free_in                = free_ff + 32'd1;
                  live_in                = live_ff - LW'(1);
               end else begin
                  rsp_in.status = STATUS_BAD_FREE;
               end
            end
            default: begin
               valid_in = '0;
               next_in  = base_ff;
               alloc_in = '0;
               free_in  = '0;
               live_in  = '0;
            end
         endcase
         rsp_in.alloc_total = alloc_in;
         rsp_in.free_total  = free_in;
         rsp_in.live_slots  = 9'(live_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= HANDLE_BASE_RESET;
         next_ff    <= HANDLE_BASE_RESET;
         alloc_ff   <= '0;
         free_ff    <= '0;
         live_ff    <= '0;
         valid_ff   <= '0;
         issue_ff   <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         base_ff    <= base_in;
         next_ff    <= next_in;
         alloc_ff   <= alloc_in;
         free_ff    <= free_in;
         live_ff    <= live_in;
         valid_ff   <= valid_in;
         issue_ff   <= issue_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_data_ff <= found_data_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   live_matches_valid: assert property (@(posedge clock) disable iff (reset)
      live_ff == LW'($countones(valid_ff)))
      else $error("live count out of step with slot marks");

   alloc_into_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (req_ff.func == FUNC_ALLOC) && found_ff) |-> !valid_ff[found_idx_ff])
      else $error("allocate into an occupied slot");

   lookup_on_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && is_lookup && found_ff) |-> valid_ff[found_idx_ff])
      else $error("read or free hit an empty slot");

endmodule

// ===== sv/tsha_ctrl.sv =====
`timescale 1ns / 1ps

module tsha_ctrl
   import tsha_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   beat_follows_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("result beat without a commit");

   commit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("commit did not post a result");

endmodule

// ===== sv/tagged_slot_heap_allocator.sv =====
`timescale 1ns / 1ps
// channel  direction  handshake              beat
// req      in         req_valid / req_ready  req_data (func, value, handle)
// rsp      out        rsp_valid / rsp_ready  rsp_data (status, handle_out, value_out, counts)
// csr      in         csr_wr_en              csr_wr_data (handle_base)
//
// one request at a time; each is accepted, then swept, then committed
// allocate: the sweep stops at the lowest free slot index (one slot mark checked per cycle)
// read / free: the sweep stops at a tag hit (registered tag ram read), or runs to the last slot on a miss
// clear and allocate-when-full: done without a sweep
// sync reset empties all slots and loads handle_base and next handle with 1000
// a waiting result holds back only the commit of the next request, not its accept or sweep

module tagged_slot_heap_allocator
   import tsha_pkg::*;
#(
   parameter int SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   tsha_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   tsha_dp #(
      .SLOTS(SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_data   (rsp_data)
   );

endmodule
